@@ design/cmpd_pkg.sv @@
// shared constants, register indexes and saturation helpers for the current measure pid block
`default_nettype none
package cmpd_pkg;

   // ring count of the radial grid
   localparam int MaxRings = 64;

   localparam int QW = 32;   // q16.16 word
   localparam int UW = 31;   // unsigned q15.16 fields
   localparam int RW = 6;    // ring index width
   localparam int MW = 33;   // multiplier operand width
   localparam int PW = 64;   // multiplier product width
   localparam int CW = 3;    // csr index width

   // csr register indexes
   localparam logic [CW-1:0] REG_SETPOINT = 3'd0;
   localparam logic [CW-1:0] REG_GAIN_P   = 3'd1;
   localparam logic [CW-1:0] REG_GAIN_I   = 3'd2;
   localparam logic [CW-1:0] REG_GAIN_D   = 3'd3;
   localparam logic [CW-1:0] REG_FLUX     = 3'd4;
   localparam logic [CW-1:0] REG_RATIO    = 3'd5;

   localparam logic [UW-1:0] UnityQ16 = 31'd65536;
   localparam logic [UW-1:0] U31Max   = 31'h7FFF_FFFF;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [MW-1:0] mop_type;
   typedef logic signed [PW-1:0] wide_type;

   // clip a wide signed value to the signed 32-bit range
   function automatic q_type sat32(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = -32'sh8000_0000;
      end else begin
         sat32 = v[QW-1:0];
      end
   endfunction

   // drop 16 fraction bits, rounding toward minus infinity
   function automatic wide_type floor16(input wide_type v);
      floor16 = v >>> 16;
   endfunction

endpackage
`default_nettype wire

@@ design/cmpd_mul.sv @@
// shared signed multiplier with registered product
`default_nettype none
module cmpd_mul (
   input  wire logic             clock,
   input  wire cmpd_pkg::mop_type op_a,
   input  wire cmpd_pkg::mop_type op_b,
   output cmpd_pkg::wide_type     prod
);
   import cmpd_pkg::*;

   wide_type prod_ff;
   wide_type prod_in;

   logic signed [2*MW-1:0] full;

   always_comb begin
      full    = op_a * op_b;
      // product magnitudes stay within 2^62 in every use
      prod_in = full[PW-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

@@ design/current_measure_pid_density_control.sv @@
// axial current measurement with positional pid control of an injection density
//
// usage:
//   req_*  one ring cell per beat: densities, axial velocities, ring index and a
//          last_cell flag. req_ready is high only while the sequencer is idle.
//   rsp_*  one beat per round, issued after the item with last_cell set:
//          density_command and the closed measured_current.
//   csr_*  register writes (index, data); always ready; the user must write them
//          only while idle, which the block itself does not enforce.
// sequencing: a ring cell with a valid ring index keeps the sequencer busy in one
//   shared 33x33 multiplier (four products in a chain plus the subtract and
//   accumulate steps, states C0 to C6), and no new cell is taken meanwhile;
//   a ring outside 1..MaxRings-1 is taken without entering those states.
//   a last cell adds the pid step (three gain products and the output scaling
//   go through the same multiplier, states P0 to P7), after which the result
//   is presented.
// reset: synchronous, clears the csr registers (flux scale and output ratio
//   to 1.0), the running sum, integral, previous error and injection level.
// stall: the result waits in an output register; new cells are taken while
//   it waits, and only the next result stalls the sequencer until rsp_ready.
`default_nettype none
module current_measure_pid_density_control (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // ring cell input
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [cmpd_pkg::UW-1:0] req_ion_density,
   input  wire logic signed [cmpd_pkg::QW-1:0] req_ion_axial_velocity,
   input  wire logic [cmpd_pkg::UW-1:0] req_electron_density,
   input  wire logic signed [cmpd_pkg::QW-1:0] req_electron_axial_velocity,
   input  wire logic [cmpd_pkg::RW-1:0] req_ring_index,
   input  wire logic                    req_last_cell,
   // result
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [cmpd_pkg::UW-1:0]      rsp_density_command,
   output logic signed [cmpd_pkg::QW-1:0] rsp_measured_current,
   // register writes
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [cmpd_pkg::CW-1:0] csr_index,
   input  wire logic [cmpd_pkg::QW-1:0] csr_wdata
);
   import cmpd_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_C0    = 4'd1;   // ni*viz
   localparam logic [3:0] ST_C1    = 4'd2;   // ne*vez, hold first product
   localparam logic [3:0] ST_C2    = 4'd3;   // flux = sat(floor(diff))
   localparam logic [3:0] ST_C3    = 4'd4;   // flux*scale
   localparam logic [3:0] ST_C4    = 4'd5;   // term = sat(floor)
   localparam logic [3:0] ST_C5    = 4'd6;   // term*weight
   localparam logic [3:0] ST_C6    = 4'd7;   // accumulate
   localparam logic [3:0] ST_P0    = 4'd8;   // error
   localparam logic [3:0] ST_P1    = 4'd9;   // integral, diff, kp*err
   localparam logic [3:0] ST_P2    = 4'd10;  // ki*integral
   localparam logic [3:0] ST_P3    = 4'd11;  // kd*diff
   localparam logic [3:0] ST_P4    = 4'd12;  // delta
   localparam logic [3:0] ST_P5    = 4'd13;  // injection level
   localparam logic [3:0] ST_P6    = 4'd14;  // level*ratio
   localparam logic [3:0] ST_P7    = 4'd15;  // output

   logic [3:0] state_ff, state_in;

   // csr registers
   q_type          setpoint_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic [UW-1:0]  flux_scale_ff, ratio_ff;

   // latched cell
   logic [UW-1:0]  ni_ff, ne_ff;
   q_type          viz_ff, vez_ff;
   logic [RW-1:0]  ring_ff;
   logic           last_ff;

   // controller state
   q_type          sum_ff, sum_in;
   q_type          integ_ff, integ_in;
   q_type          prev_ff, prev_in;
   q_type          inj_ff, inj_in;

   // scratch
   wide_type       acc_ff, acc_in;
   q_type          x_ff, x_in;       // flux, term or delta
   q_type          err_ff, err_in;
   q_type          diff_ff, diff_in;
   q_type          meas_ff, meas_in;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [UW-1:0]  cmd_ff, cmd_in;
   q_type          rsp_meas_ff, rsp_meas_in;

   mop_type        op_a, op_b;
   wide_type       prod;

   logic           req_take;
   logic           ring_ok;
   logic [RW:0]    weight;
   wide_type       fl;
   wide_type       lvl;

   cmpd_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // ring zero and rings past the grid add nothing
   assign ring_ok = (req_ring_index != '0) && (int'(req_ring_index) < MaxRings);
   assign weight  = {ring_ff, 1'b0} - {{RW{1'b0}}, 1'b1};
   assign fl      = floor16(prod);

   // multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_C0: begin
            op_a = mop_type'({2'b00, ni_ff});
            op_b = mop_type'({viz_ff[QW-1], viz_ff});
         end
         ST_C1: begin
            op_a = mop_type'({2'b00, ne_ff});
            op_b = mop_type'({vez_ff[QW-1], vez_ff});
         end
         ST_C3: begin
            op_a = mop_type'({x_ff[QW-1], x_ff});
            op_b = mop_type'({2'b00, flux_scale_ff});
         end
         ST_C5: begin
            op_a = mop_type'({x_ff[QW-1], x_ff});
            op_b = mop_type'({{(MW-RW-1){1'b0}}, weight});
         end
         ST_P1: begin
            op_a = mop_type'({gain_p_ff[QW-1], gain_p_ff});
            op_b = mop_type'({err_ff[QW-1], err_ff});
         end
         ST_P2: begin
            op_a = mop_type'({gain_i_ff[QW-1], gain_i_ff});
            op_b = mop_type'({integ_ff[QW-1], integ_ff});
         end
         ST_P3: begin
            op_a = mop_type'({gain_d_ff[QW-1], gain_d_ff});
            op_b = mop_type'({diff_ff[QW-1], diff_ff});
         end
         ST_P6, ST_P7: begin
            // operands held while the output waits so the product stays put
            op_a = mop_type'({inj_ff[QW-1], inj_ff});
            op_b = mop_type'({2'b00, ratio_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      inj_in       = inj_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      meas_in      = meas_ff;
      cmd_in       = cmd_ff;
      rsp_meas_in  = rsp_meas_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      lvl          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (ring_ok) begin
                  state_in = ST_C0;
               end else if (req_last_cell) begin
                  state_in = ST_P0;
               end
            end
         end
         ST_C0: state_in = ST_C1;
         ST_C1: begin
            acc_in   = prod;
            state_in = ST_C2;
         end
         ST_C2: begin
            // products stay below 2^62, so the difference cannot wrap
            x_in     = sat32(floor16(acc_ff - prod));
            state_in = ST_C3;
         end
         ST_C3: state_in = ST_C4;
         ST_C4: begin
            x_in     = sat32(fl);
            state_in = ST_C5;
         end
         ST_C5: state_in = ST_C6;
         ST_C6: begin
            sum_in   = sat32(wide_type'(sum_ff) + wide_type'(sat32(prod)));
            state_in = last_ff ? ST_P0 : ST_IDLE;
         end
         ST_P0: begin
            err_in   = sat32(wide_type'(setpoint_ff) + wide_type'(sum_ff));
            meas_in  = sum_ff;
            sum_in   = '0;
            state_in = ST_P1;
         end
         ST_P1: begin
            integ_in = sat32(wide_type'(integ_ff) + wide_type'(err_ff));
            diff_in  = sat32(wide_type'(err_ff) - wide_type'(prev_ff));
            prev_in  = err_ff;
            state_in = ST_P2;
         end
         ST_P2: begin
            acc_in   = fl;
            state_in = ST_P3;
         end
         ST_P3: begin
            acc_in   = acc_ff + fl;
            state_in = ST_P4;
         end
         ST_P4: begin
            x_in     = sat32(acc_ff + fl);
            state_in = ST_P5;
         end
         ST_P5: begin
            // negative levels clamp to zero
            lvl      = wide_type'(sat32(wide_type'(inj_ff) + wide_type'(x_ff)));
            inj_in   = lvl[PW-1] ? '0 : lvl[QW-1:0];
            state_in = ST_P6;
         end
         ST_P6: state_in = ST_P7;
         ST_P7: begin
            // wait here only while an earlier result is still unread
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_in       = (fl > wide_type'(U31Max)) ? U31Max : fl[UW-1:0];
               rsp_meas_in  = meas_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         sum_ff        <= '0;
         integ_ff      <= '0;
         prev_ff       <= '0;
         inj_ff        <= '0;
         setpoint_ff   <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         flux_scale_ff <= UnityQ16;
         ratio_ff      <= UnityQ16;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         inj_ff       <= inj_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SETPOINT: setpoint_ff   <= csr_wdata;
               REG_GAIN_P:   gain_p_ff     <= csr_wdata;
               REG_GAIN_I:   gain_i_ff     <= csr_wdata;
               REG_GAIN_D:   gain_d_ff     <= csr_wdata;
               REG_FLUX:     flux_scale_ff <= csr_wdata[UW-1:0];
               REG_RATIO:    ratio_ff      <= csr_wdata[UW-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload and scratch
   always_ff @(posedge clock) begin
      if (req_take) begin
         ni_ff   <= req_ion_density;
         viz_ff  <= req_ion_axial_velocity;
         ne_ff   <= req_electron_density;
         vez_ff  <= req_electron_axial_velocity;
         ring_ff <= req_ring_index;
         last_ff <= req_last_cell;
      end
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      meas_ff     <= meas_in;
      cmd_ff      <= cmd_in;
      rsp_meas_ff <= rsp_meas_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_density_command  = cmd_ff;
   assign rsp_measured_current = rsp_meas_ff;

endmodule
`default_nettype wire
